[rtl/spm_pkg.sv]
// spm_pkg: sizes, codes and the sequencer state type of the slotted page record manager
// no dependencies; the manager and the checkers refer to it by scoped names

package spm_pkg;

    localparam int PAGE_BYTES = 1024;
    localparam int SLOT_BYTES = 4;
    localparam int MAX_SLOTS  = 256;

    localparam int PAGE_AW = $clog2(PAGE_BYTES);
    localparam int SLOT_AW = $clog2(MAX_SLOTS);
    localparam int CNT_W   = SLOT_AW + 1;
    localparam int LEN_W   = PAGE_AW + 1;
    localparam int PTR_W   = PAGE_AW + 3;
    localparam int SLOT_DW = LEN_W + PAGE_AW;

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_WRITE  = 3'd1;
    localparam logic [2:0] ACT_DELETE = 3'd2;
    localparam logic [2:0] ACT_READ   = 3'd3;
    localparam logic [2:0] ACT_FIRST  = 3'd4;
    localparam logic [2:0] ACT_NEXT   = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_INS_SCAN,
        S_INS_PRE,
        S_INS_GROW,
        S_INS_FIT,
        S_INS_ALLOC,
        S_INS_ZERO,
        S_RW_CHECK,
        S_RW_DATA,
        S_DEL_GET,
        S_DEL_RD,
        S_DEL_CMP,
        S_DEL_END,
        S_FN_SCAN,
        S_FN_LEN,
        S_CP_INIT,
        S_CP_RD,
        S_CP_CMP,
        S_CP_SEL,
        S_CP_BRD,
        S_CP_BWR,
        S_FINISH
    } state_t;

endpackage

[rtl/spm_ram.sv]
// spm_ram: generic single-port ram with registered read
// no dependencies

module spm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/slotted_page_record_manager.sv]
// slotted_page_record_manager: one slotted page with its slot directory and sequencer
// depends on spm_pkg and spm_ram (page byte store and slot directory store)
//
// Usage: the request channel (in_valid/in_ready) carries one operation per beat,
// the result channel (out_valid/out_ready) returns exactly one result beat for it.
// cfg_we/cfg_wdata set the page number; write it only while the block is idle.
// One operation is worked on at a time; in_ready is high only while idle.
// Work per operation: a byte write checks the bounds and writes, a byte read
// also fetches the byte; first/next scan the slots; delete reads every slot to
// find the lowest record (not when the last record goes); insert scans for a
// free slot or appends one and zero-fills the record. When the gap is too small,
// a compaction first moves each record byte by byte, scanning the slots for each.
// The single-port stores serialize all of these steps.
// Reset empties the page (no slots, full free space, page number zero); the
// byte and directory stores are not cleared.
// A stalled receiver holds the result in the output register; a new request is
// still accepted and worked on, and its result waits until the register frees.

module slotted_page_record_manager (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [15:0] request_page,
    input  logic [7:0]  slot_index,
    input  logic [10:0] record_length,
    input  logic [9:0]  byte_index,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  result_slot,
    output logic [10:0] result_length,
    output logic [7:0]  result_byte,
    output logic [10:0] free_space,
    output logic [8:0]  record_count
);

    localparam int PAGE_AW = spm_pkg::PAGE_AW;
    localparam int SLOT_AW = spm_pkg::SLOT_AW;
    localparam int CNT_W   = spm_pkg::CNT_W;
    localparam int LEN_W   = spm_pkg::LEN_W;
    localparam int PTR_W   = spm_pkg::PTR_W;
    localparam int SLOT_DW = spm_pkg::SLOT_DW;
    localparam int NSLOT   = spm_pkg::MAX_SLOTS;

    spm_pkg::state_t state_reg, state_next, ret_reg, ret_next;

    logic [15:0]              page_num_reg;
    logic [2:0]               act_reg, act_next;
    logic [15:0]              rpage_reg, rpage_next;
    logic [7:0]               slot_reg, slot_next;
    logic [10:0]              len_reg, len_next;
    logic [9:0]               bidx_reg, bidx_next;
    logic [7:0]               dbyte_reg, dbyte_next;
    logic [CNT_W-1:0]         i_reg, i_next;
    logic [SLOT_AW-1:0]       idx_reg, idx_next;
    logic [LEN_W-1:0]         k_reg, k_next;
    logic [CNT_W-1:0]         sc_reg, sc_next;
    logic [CNT_W-1:0]         nvalid_reg, nvalid_next;
    logic signed [PTR_W-1:0]  fp_reg, fp_next;
    logic [LEN_W-1:0]         ft_reg, ft_next;
    logic [NSLOT-1:0]         valid_reg, valid_next;
    logic [NSLOT-1:0]         mark_reg, mark_next;
    logic signed [PTR_W-1:0]  cend_reg, cend_next;
    logic                     pick_valid_reg, pick_valid_next;
    logic [SLOT_AW-1:0]       pick_reg, pick_next;
    logic [PAGE_AW-1:0]       pick_off_reg, pick_off_next;
    logic [LEN_W-1:0]         pick_len_reg, pick_len_next;
    logic [PAGE_AW-1:0]       src_reg, src_next;
    logic [PAGE_AW-1:0]       dst_reg, dst_next;
    logic [PAGE_AW-1:0]       off_reg, off_next;
    logic [LEN_W-1:0]         rec_len_reg, rec_len_next;
    logic [PAGE_AW-1:0]       rec_off_reg, rec_off_next;
    logic [LEN_W-1:0]         small_reg, small_next;
    logic [1:0]               res_status_reg, res_status_next;
    logic [7:0]               res_slot_reg, res_slot_next;
    logic [10:0]              res_len_reg, res_len_next;
    logic [7:0]               res_byte_reg, res_byte_next;

    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               out_status_reg, out_status_next;
    logic [7:0]               out_slot_reg, out_slot_next;
    logic [10:0]              out_len_reg, out_len_next;
    logic [7:0]               out_byte_reg, out_byte_next;
    logic [10:0]              out_free_reg, out_free_next;
    logic [8:0]               out_count_reg, out_count_next;

    // store ports
    logic                     page_we;
    logic [PAGE_AW-1:0]       page_addr;
    logic [7:0]               page_wdata, page_rdata;
    logic                     slot_we;
    logic [SLOT_AW-1:0]       slot_addr;
    logic [SLOT_DW-1:0]       slot_wdata, slot_rdata;
    logic [LEN_W-1:0]         rd_len;
    logic [PAGE_AW-1:0]       rd_off;

    // shared arithmetic
    logic signed [PTR_W:0]    sc_bytes, gap, need_fit, need_grow;
    logic signed [PTR_W-1:0]  fp_alloc, off_alloc, cp_dst;
    logic                     zero_ok, copy_ok;
    logic                     in_accept, out_free, addressed, full;
    logic [LEN_W-1:0]         pos;
    logic                     rw_ok;

    spm_ram #(.WIDTH(8), .DEPTH(spm_pkg::PAGE_BYTES)) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .addr  (page_addr),
        .wdata (page_wdata),
        .rdata (page_rdata)
    );

    spm_ram #(.WIDTH(SLOT_DW), .DEPTH(NSLOT)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .addr  (slot_addr),
        .wdata (slot_wdata),
        .rdata (slot_rdata)
    );

    assign rd_len = slot_rdata[SLOT_DW-1:PAGE_AW];
    assign rd_off = slot_rdata[PAGE_AW-1:0];

    assign in_ready  = (state_reg == spm_pkg::S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign sc_bytes  = signed'((PTR_W+1)'(sc_reg * spm_pkg::SLOT_BYTES));
    assign gap       = {fp_reg[PTR_W-1], fp_reg} - sc_bytes + (PTR_W+1)'(1);
    assign need_fit  = signed'((PTR_W+1)'(len_reg));
    assign need_grow = need_fit + (PTR_W+1)'(spm_pkg::SLOT_BYTES);

    assign fp_alloc  = fp_reg - signed'(PTR_W'(len_reg));
    assign off_alloc = fp_alloc + PTR_W'(1);
    assign zero_ok   = !off_alloc[PTR_W-1]
                       && (({1'b0, off_alloc} + (PTR_W+1)'(len_reg))
                           <= (PTR_W+1)'(spm_pkg::PAGE_BYTES));

    assign cp_dst    = cend_reg - signed'(PTR_W'(pick_len_reg));
    assign copy_ok   = !cp_dst[PTR_W-1]
                       && (({1'b0, pick_off_reg} + {1'b0, pick_len_reg})
                           <= (LEN_W+1)'(spm_pkg::PAGE_BYTES));

    assign addressed = (rpage_reg == page_num_reg) && ({1'b0, slot_reg} < sc_reg)
                       && valid_reg[slot_reg];
    assign full      = (nvalid_reg == sc_reg);

    assign pos   = {1'b0, rd_off} + {1'b0, bidx_reg};
    assign rw_ok = ({1'b0, bidx_reg} < rd_len) && (pos < LEN_W'(spm_pkg::PAGE_BYTES));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spm_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = spm_pkg::S_DECODE;
                end
            end
            spm_pkg::S_DECODE:
            begin
                case (act_reg)
                    spm_pkg::ACT_INSERT:
                    begin
                        if (len_reg == '0)
                        begin
                            state_next = spm_pkg::S_FINISH;
                        end
                        else if (full)
                        begin
                            if (({1'b0, ft_reg} < ({1'b0, len_reg}
                                    + (LEN_W+1)'(spm_pkg::SLOT_BYTES)))
                                || (sc_reg >= CNT_W'(NSLOT)))
                            begin
                                state_next = spm_pkg::S_FINISH;
                            end
                            else
                            begin
                                state_next = spm_pkg::S_INS_PRE;
                            end
                        end
                        else if (ft_reg < len_reg)
                        begin
                            state_next = spm_pkg::S_FINISH;
                        end
                        else
                        begin
                            state_next = spm_pkg::S_INS_SCAN;
                        end
                    end
                    spm_pkg::ACT_WRITE, spm_pkg::ACT_READ:
                    begin
                        state_next = addressed ? spm_pkg::S_RW_CHECK : spm_pkg::S_FINISH;
                    end
                    spm_pkg::ACT_DELETE:
                    begin
                        state_next = addressed ? spm_pkg::S_DEL_GET : spm_pkg::S_FINISH;
                    end
                    spm_pkg::ACT_FIRST:
                    begin
                        state_next = spm_pkg::S_FN_SCAN;
                    end
                    spm_pkg::ACT_NEXT:
                    begin
                        if ((rpage_reg != page_num_reg) || ({1'b0, slot_reg} >= sc_reg))
                        begin
                            state_next = spm_pkg::S_FINISH;
                        end
                        else
                        begin
                            state_next = spm_pkg::S_FN_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = spm_pkg::S_FINISH;
                    end
                endcase
            end
            spm_pkg::S_INS_SCAN:
            begin
                if (!valid_reg[i_reg[SLOT_AW-1:0]] || (i_reg >= sc_reg))
                begin
                    state_next = spm_pkg::S_INS_FIT;
                end
            end
            spm_pkg::S_INS_PRE:
            begin
                state_next = (gap < need_grow) ? spm_pkg::S_CP_INIT : spm_pkg::S_INS_GROW;
            end
            spm_pkg::S_INS_GROW:
            begin
                state_next = spm_pkg::S_INS_FIT;
            end
            spm_pkg::S_INS_FIT:
            begin
                state_next = (gap < need_fit) ? spm_pkg::S_CP_INIT : spm_pkg::S_INS_ALLOC;
            end
            spm_pkg::S_INS_ALLOC:
            begin
                state_next = spm_pkg::S_INS_ZERO;
            end
            spm_pkg::S_INS_ZERO:
            begin
                if (k_reg == len_reg)
                begin
                    state_next = spm_pkg::S_FINISH;
                end
            end
            spm_pkg::S_RW_CHECK:
            begin
                if (rw_ok && (act_reg == spm_pkg::ACT_READ))
                begin
                    state_next = spm_pkg::S_RW_DATA;
                end
                else
                begin
                    state_next = spm_pkg::S_FINISH;
                end
            end
            spm_pkg::S_RW_DATA:
            begin
                state_next = spm_pkg::S_FINISH;
            end
            spm_pkg::S_DEL_GET:
            begin
                state_next = (nvalid_reg == CNT_W'(1)) ? spm_pkg::S_FINISH : spm_pkg::S_DEL_RD;
            end
            spm_pkg::S_DEL_RD:
            begin
                state_next = (i_reg == sc_reg) ? spm_pkg::S_DEL_END : spm_pkg::S_DEL_CMP;
            end
            spm_pkg::S_DEL_CMP:
            begin
                state_next = spm_pkg::S_DEL_RD;
            end
            spm_pkg::S_DEL_END:
            begin
                state_next = spm_pkg::S_FINISH;
            end
            spm_pkg::S_FN_SCAN:
            begin
                if (i_reg >= sc_reg)
                begin
                    state_next = spm_pkg::S_FINISH;
                end
                else if (valid_reg[i_reg[SLOT_AW-1:0]])
                begin
                    state_next = spm_pkg::S_FN_LEN;
                end
            end
            spm_pkg::S_FN_LEN:
            begin
                state_next = spm_pkg::S_FINISH;
            end
            spm_pkg::S_CP_INIT:
            begin
                state_next = spm_pkg::S_CP_RD;
            end
            spm_pkg::S_CP_RD:
            begin
                state_next = (i_reg == sc_reg) ? spm_pkg::S_CP_SEL : spm_pkg::S_CP_CMP;
            end
            spm_pkg::S_CP_CMP:
            begin
                state_next = spm_pkg::S_CP_RD;
            end
            spm_pkg::S_CP_SEL:
            begin
                state_next = pick_valid_reg ? spm_pkg::S_CP_BRD : ret_reg;
            end
            spm_pkg::S_CP_BRD:
            begin
                state_next = (k_reg == '0) ? spm_pkg::S_CP_RD : spm_pkg::S_CP_BWR;
            end
            spm_pkg::S_CP_BWR:
            begin
                state_next = spm_pkg::S_CP_BRD;
            end
            spm_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = spm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spm_pkg::S_IDLE;
            end
        endcase
    end

    // datapath, store ports and results
    always_comb
    begin
        ret_next        = ret_reg;
        act_next        = act_reg;
        rpage_next      = rpage_reg;
        slot_next       = slot_reg;
        len_next        = len_reg;
        bidx_next       = bidx_reg;
        dbyte_next      = dbyte_reg;
        i_next          = i_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        sc_next         = sc_reg;
        nvalid_next     = nvalid_reg;
        fp_next         = fp_reg;
        ft_next         = ft_reg;
        valid_next      = valid_reg;
        mark_next       = mark_reg;
        cend_next       = cend_reg;
        pick_valid_next = pick_valid_reg;
        pick_next       = pick_reg;
        pick_off_next   = pick_off_reg;
        pick_len_next   = pick_len_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        off_next        = off_reg;
        rec_len_next    = rec_len_reg;
        rec_off_next    = rec_off_reg;
        small_next      = small_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_len_next    = res_len_reg;
        res_byte_next   = res_byte_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_len_next    = out_len_reg;
        out_byte_next   = out_byte_reg;
        out_free_next   = out_free_reg;
        out_count_next  = out_count_reg;
        page_we         = 1'b0;
        page_addr       = off_reg + k_reg[PAGE_AW-1:0];
        page_wdata      = '0;
        slot_we         = 1'b0;
        slot_addr       = slot_reg;
        slot_wdata      = {len_reg, off_reg};

        case (state_reg)
            spm_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    act_next   = action;
                    rpage_next = request_page;
                    slot_next  = slot_index;
                    len_next   = record_length;
                    bidx_next  = byte_index;
                    dbyte_next = data_byte;
                end
            end
            spm_pkg::S_DECODE:
            begin
                res_status_next = spm_pkg::ST_FAIL;
                res_slot_next   = '0;
                res_len_next    = '0;
                res_byte_next   = '0;
                i_next          = '0;
                idx_next        = sc_reg[SLOT_AW-1:0];
                case (act_reg)
                    spm_pkg::ACT_INSERT:
                    begin
                        if (len_reg != '0)
                        begin
                            res_status_next = spm_pkg::ST_DONE;
                        end
                    end
                    spm_pkg::ACT_FIRST, spm_pkg::ACT_NEXT:
                    begin
                        if (act_reg == spm_pkg::ACT_NEXT)
                        begin
                            i_next = CNT_W'(slot_reg) + CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        i_next = '0;
                    end
                endcase
            end
            spm_pkg::S_INS_SCAN:
            begin
                idx_next = i_reg[SLOT_AW-1:0];
                i_next   = i_reg + CNT_W'(1);
                ret_next = spm_pkg::S_INS_ALLOC;
            end
            spm_pkg::S_INS_PRE:
            begin
                ret_next = spm_pkg::S_INS_GROW;
            end
            spm_pkg::S_INS_GROW:
            begin
                ft_next  = ft_reg - LEN_W'(spm_pkg::SLOT_BYTES);
                sc_next  = sc_reg + CNT_W'(1);
                ret_next = spm_pkg::S_INS_ALLOC;
            end
            spm_pkg::S_INS_ALLOC:
            begin
                fp_next         = fp_alloc;
                ft_next         = ft_reg - len_reg;
                off_next        = off_alloc[PAGE_AW-1:0];
                k_next          = zero_ok ? '0 : len_reg;
                slot_we         = 1'b1;
                slot_addr       = idx_reg;
                slot_wdata      = {len_reg, off_alloc[PAGE_AW-1:0]};
                valid_next[idx_reg] = 1'b1;
                nvalid_next     = nvalid_reg + CNT_W'(1);
                res_status_next = spm_pkg::ST_OK;
                res_slot_next   = 8'(idx_reg);
            end
            spm_pkg::S_INS_ZERO:
            begin
                // new record reads as zero until written
                if (k_reg != len_reg)
                begin
                    page_we = 1'b1;
                    k_next  = k_reg + LEN_W'(1);
                end
            end
            spm_pkg::S_RW_CHECK:
            begin
                page_addr = pos[PAGE_AW-1:0];
                if (rw_ok)
                begin
                    res_status_next = spm_pkg::ST_OK;
                    res_len_next    = rd_len;
                    if (act_reg == spm_pkg::ACT_WRITE)
                    begin
                        page_we    = 1'b1;
                        page_wdata = dbyte_reg;
                    end
                end
            end
            spm_pkg::S_RW_DATA:
            begin
                res_byte_next = page_rdata;
            end
            spm_pkg::S_DEL_GET:
            begin
                rec_len_next = rd_len;
                rec_off_next = rd_off;
                small_next   = '1;
                if (nvalid_reg == CNT_W'(1))
                begin
                    // last record gone: the page is empty again
                    ft_next          = LEN_W'(ft_reg + sc_bytes[LEN_W-1:0] + rd_len);
                    fp_next          = PTR_W'(spm_pkg::PAGE_BYTES - 1);
                    sc_next          = '0;
                    valid_next[slot_reg] = 1'b0;
                    nvalid_next      = '0;
                    res_status_next  = spm_pkg::ST_OK;
                end
            end
            spm_pkg::S_DEL_RD:
            begin
                slot_addr = i_reg[SLOT_AW-1:0];
            end
            spm_pkg::S_DEL_CMP:
            begin
                if (valid_reg[i_reg[SLOT_AW-1:0]] && ({1'b0, rd_off} < small_reg))
                begin
                    small_next = {1'b0, rd_off};
                end
                i_next = i_reg + CNT_W'(1);
            end
            spm_pkg::S_DEL_END:
            begin
                if (small_reg == {1'b0, rec_off_reg})
                begin
                    fp_next = fp_reg + signed'(PTR_W'(rec_len_reg));
                end
                if (CNT_W'(slot_reg) == (sc_reg - CNT_W'(1)))
                begin
                    sc_next = sc_reg - CNT_W'(1);
                    ft_next = ft_reg + LEN_W'(spm_pkg::SLOT_BYTES) + rec_len_reg;
                end
                else
                begin
                    ft_next = ft_reg + rec_len_reg;
                end
                valid_next[slot_reg] = 1'b0;
                nvalid_next          = nvalid_reg - CNT_W'(1);
                res_status_next      = spm_pkg::ST_OK;
            end
            spm_pkg::S_FN_SCAN:
            begin
                slot_addr = i_reg[SLOT_AW-1:0];
                idx_next  = i_reg[SLOT_AW-1:0];
                i_next    = i_reg + CNT_W'(1);
                if (i_reg >= sc_reg)
                begin
                    res_status_next = spm_pkg::ST_DONE;
                end
            end
            spm_pkg::S_FN_LEN:
            begin
                res_status_next = spm_pkg::ST_OK;
                res_slot_next   = 8'(idx_reg);
                res_len_next    = rd_len;
            end
            spm_pkg::S_CP_INIT:
            begin
                mark_next       = '0;
                cend_next       = PTR_W'(spm_pkg::PAGE_BYTES);
                i_next          = '0;
                pick_valid_next = 1'b0;
            end
            spm_pkg::S_CP_RD:
            begin
                slot_addr = i_reg[SLOT_AW-1:0];
            end
            spm_pkg::S_CP_CMP:
            begin
                // highest unmoved offset goes next
                if (valid_reg[i_reg[SLOT_AW-1:0]] && !mark_reg[i_reg[SLOT_AW-1:0]]
                    && (!pick_valid_reg || (rd_off > pick_off_reg)))
                begin
                    pick_valid_next = 1'b1;
                    pick_next       = i_reg[SLOT_AW-1:0];
                    pick_off_next   = rd_off;
                    pick_len_next   = rd_len;
                end
                i_next = i_reg + CNT_W'(1);
            end
            spm_pkg::S_CP_SEL:
            begin
                if (!pick_valid_reg)
                begin
                    fp_next = cend_reg - PTR_W'(1);
                end
                else
                begin
                    mark_next[pick_reg] = 1'b1;
                    slot_we    = 1'b1;
                    slot_addr  = pick_reg;
                    slot_wdata = {pick_len_reg, cp_dst[PAGE_AW-1:0]};
                    k_next     = copy_ok ? pick_len_reg : '0;
                    src_next   = pick_off_reg;
                    dst_next   = cp_dst[PAGE_AW-1:0];
                    cend_next  = cp_dst;
                end
            end
            spm_pkg::S_CP_BRD:
            begin
                // bytes move upward, so copy from the top byte down
                page_addr = src_reg + PAGE_AW'(k_reg - LEN_W'(1));
                if (k_reg == '0)
                begin
                    i_next          = '0;
                    pick_valid_next = 1'b0;
                end
            end
            spm_pkg::S_CP_BWR:
            begin
                page_we    = 1'b1;
                page_addr  = dst_reg + PAGE_AW'(k_reg - LEN_W'(1));
                page_wdata = page_rdata;
                k_next     = k_reg - LEN_W'(1);
            end
            spm_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_len_next    = res_len_reg;
                    out_byte_next   = res_byte_reg;
                    out_free_next   = ft_reg;
                    out_count_next  = nvalid_reg;
                end
            end
            default:
            begin
                page_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= spm_pkg::S_IDLE;
            ret_reg        <= spm_pkg::S_IDLE;
            page_num_reg   <= '0;
            sc_reg         <= '0;
            nvalid_reg     <= '0;
            fp_reg         <= PTR_W'(spm_pkg::PAGE_BYTES - 1);
            ft_reg         <= LEN_W'(spm_pkg::PAGE_BYTES);
            valid_reg      <= '0;
            mark_reg       <= '0;
            pick_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            if (cfg_we)
            begin
                page_num_reg <= cfg_wdata;
            end
            sc_reg         <= sc_next;
            nvalid_reg     <= nvalid_next;
            fp_reg         <= fp_next;
            ft_reg         <= ft_next;
            valid_reg      <= valid_next;
            mark_reg       <= mark_next;
            pick_valid_reg <= pick_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        rpage_reg      <= rpage_next;
        slot_reg       <= slot_next;
        len_reg        <= len_next;
        bidx_reg       <= bidx_next;
        dbyte_reg      <= dbyte_next;
        i_reg          <= i_next;
        idx_reg        <= idx_next;
        k_reg          <= k_next;
        cend_reg       <= cend_next;
        pick_reg       <= pick_next;
        pick_off_reg   <= pick_off_next;
        pick_len_reg   <= pick_len_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        off_reg        <= off_next;
        rec_len_reg    <= rec_len_next;
        rec_off_reg    <= rec_off_next;
        small_reg      <= small_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_len_reg    <= res_len_next;
        res_byte_reg   <= res_byte_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_len_reg    <= out_len_next;
        out_byte_reg   <= out_byte_next;
        out_free_reg   <= out_free_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign result_slot   = out_slot_reg;
    assign result_length = out_len_reg;
    assign result_byte   = out_byte_reg;
    assign free_space    = out_free_reg;
    assign record_count  = out_count_reg;

endmodule

[rtl/spm_checker.sv]
// spm_checker: port-level checks of the slotted page record manager, bound to the top level
// depends on spm_pkg and slotted_page_record_manager

module spm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [7:0]  result_slot,
    input logic [10:0] result_length,
    input logic [7:0]  result_byte,
    input logic [10:0] free_space,
    input logic [8:0]  record_count
);

    // a waiting result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(result_slot)
            && $stable(result_length) && $stable(result_byte))
        else $error("result beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared one cycle after request");

    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (record_count <= 9'(spm_pkg::MAX_SLOTS))
            && (free_space <= 11'(spm_pkg::PAGE_BYTES)))
        else $error("count or free space out of range");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == spm_pkg::ST_FAIL) |-> (result_slot == '0)
            && (result_length == '0) && (result_byte == '0))
        else $error("failed result carries data");

endmodule

bind slotted_page_record_manager spm_checker u_spm_checker (.*);

[dv/spm_page_checker.sv]
// spm_page_checker: watches the request and result channels of slotted_page_record_manager,
// predicts each result from its own copy of the page and compares it field by field
// depends on spm_pkg for sizes and codes
`timescale 1ns / 1ps

module spm_page_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [15:0]                     cfg_wdata,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [2:0]                      action,
    input  logic [15:0]                     request_page,
    input  logic [7:0]                      slot_index,
    input  logic [10:0]                     record_length,
    input  logic [9:0]                      byte_index,
    input  logic [7:0]                      data_byte,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [1:0]                      status,
    input  logic [7:0]                      result_slot,
    input  logic [10:0]                     result_length,
    input  logic [7:0]                      result_byte,
    input  logic [10:0]                     free_space,
    input  logic [8:0]                      record_count,
    output int                              errors,
    output int                              pending,
    output logic [spm_pkg::MAX_SLOTS-1:0]   live_mask,
    output logic [spm_pkg::MAX_SLOTS*11-1:0] len_flat
);

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot;
        logic [10:0] length;
        logic [7:0]  data;
        logic [10:0] free;
        logic [8:0]  count;
    } page_result_t;

    page_result_t result_fifo[$];

    logic [7:0]  page_mem[spm_pkg::PAGE_BYTES];
    int          rec_off[spm_pkg::MAX_SLOTS];
    int          rec_len[spm_pkg::MAX_SLOTS];
    bit          rec_live[spm_pkg::MAX_SLOTS];
    bit          moved[spm_pkg::MAX_SLOTS];
    int          slots_used;
    int          gap_top;
    int          free_bytes;
    logic [15:0] page_id;

    function automatic int live_records();
        int n;
        n = 0;
        for (int i = 0; i < slots_used; i++)
            if (rec_live[i]) n++;
        return n;
    endfunction

    function automatic int hole();
        return gap_top - slots_used * spm_pkg::SLOT_BYTES + 1;
    endfunction

    // repack live records against the page end, highest offset first
    task automatic repack();
        int top_end;
        int pick;
        int len;
        int src;
        int dst;
        logic [7:0] tmp[spm_pkg::PAGE_BYTES];
        top_end = spm_pkg::PAGE_BYTES;
        foreach (moved[i]) moved[i] = 0;
        forever
        begin
            pick = -1;
            for (int i = 0; i < slots_used; i++)
            begin
                if (!rec_live[i] || moved[i]) continue;
                if (pick < 0 || rec_off[i] > rec_off[pick]) pick = i;
            end
            if (pick < 0) break;
            moved[pick] = 1;
            len = rec_len[pick];
            src = rec_off[pick];
            dst = top_end - len;
            if (dst >= 0 && src >= 0 && src + len <= spm_pkg::PAGE_BYTES)
            begin
                for (int k = 0; k < len; k++) tmp[k] = page_mem[src + k];
                for (int k = 0; k < len; k++) page_mem[dst + k] = tmp[k];
            end
            rec_off[pick] = dst;
            top_end = dst;
        end
        gap_top = top_end - 1;
    endtask

    task automatic predict_page_op(output page_result_t r);
        int nvalid;
        int avail;
        int idx;
        int off;
        int len;
        int pos;
        int sl;
        int rl;
        int bi;
        int smallest;
        int start;
        bit ok;
        sl = slot_index;
        rl = record_length;
        bi = byte_index;
        r = '0;
        r.status = spm_pkg::ST_FAIL;
        case (action)
            spm_pkg::ACT_INSERT:
            begin
                nvalid = live_records();
                avail = (nvalid != slots_used) ? free_bytes
                                               : free_bytes - spm_pkg::SLOT_BYTES;
                if (rl == 0)
                    r.status = spm_pkg::ST_FAIL;
                else if (avail < rl
                         || (nvalid == slots_used && slots_used >= spm_pkg::MAX_SLOTS))
                    r.status = spm_pkg::ST_DONE;
                else
                begin
                    idx = 0;
                    while (idx < slots_used && rec_live[idx]) idx++;
                    if (idx == slots_used)
                    begin
                        if (hole() < spm_pkg::SLOT_BYTES + rl) repack();
                        free_bytes -= spm_pkg::SLOT_BYTES;
                        slots_used++;
                    end
                    if (hole() < rl) repack();
                    gap_top -= rl;
                    free_bytes -= rl;
                    off = gap_top + 1;
                    if (off >= 0 && off + rl <= spm_pkg::PAGE_BYTES)
                        for (int k = 0; k < rl; k++) page_mem[off + k] = '0;
                    rec_off[idx] = off;
                    rec_len[idx] = rl;
                    rec_live[idx] = 1;
                    r.status = spm_pkg::ST_OK;
                    r.slot = idx[7:0];
                end
            end
            spm_pkg::ACT_WRITE, spm_pkg::ACT_READ:
            begin
                if (request_page == page_id && sl < slots_used && rec_live[sl]
                    && bi < rec_len[sl])
                begin
                    pos = rec_off[sl] + bi;
                    if (pos >= 0 && pos < spm_pkg::PAGE_BYTES)
                    begin
                        if (action == spm_pkg::ACT_WRITE) page_mem[pos] = data_byte;
                        else r.data = page_mem[pos];
                        r.length = rec_len[sl][10:0];
                        r.status = spm_pkg::ST_OK;
                    end
                end
            end
            spm_pkg::ACT_DELETE:
            begin
                if (request_page == page_id && sl < slots_used && rec_live[sl])
                begin
                    len = rec_len[sl];
                    if (live_records() == 1)
                    begin
                        free_bytes += slots_used * spm_pkg::SLOT_BYTES + len;
                        gap_top = spm_pkg::PAGE_BYTES - 1;
                        slots_used = 0;
                    end
                    else
                    begin
                        // lowest record going back means the gap grows by its length
                        smallest = 32'h7fffffff;
                        for (int i = 0; i < slots_used; i++)
                            if (rec_live[i] && rec_off[i] < smallest) smallest = rec_off[i];
                        if (smallest == rec_off[sl]) gap_top += len;
                        if (sl == slots_used - 1)
                        begin
                            slots_used--;
                            free_bytes += spm_pkg::SLOT_BYTES + len;
                        end
                        else
                            free_bytes += len;
                    end
                    rec_live[sl] = 0;
                    r.status = spm_pkg::ST_OK;
                end
            end
            spm_pkg::ACT_FIRST, spm_pkg::ACT_NEXT:
            begin
                start = 0;
                ok = 1;
                if (action == spm_pkg::ACT_NEXT)
                begin
                    if (request_page != page_id || sl >= slots_used) ok = 0;
                    start = sl + 1;
                end
                if (ok)
                begin
                    r.status = spm_pkg::ST_DONE;
                    for (int i = start; i < slots_used; i++)
                    begin
                        if (rec_live[i])
                        begin
                            r.status = spm_pkg::ST_OK;
                            r.slot = i[7:0];
                            r.length = rec_len[i][10:0];
                            break;
                        end
                    end
                end
            end
            default: r.status = spm_pkg::ST_FAIL;
        endcase
        r.free = free_bytes[10:0];
        r.count = 9'(live_records());
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        page_result_t exp_r;
        if (!rst_n)
        begin
            result_fifo.delete();
            foreach (rec_live[i]) rec_live[i] = 0;
            foreach (page_mem[i]) page_mem[i] = '0;
            slots_used = 0;
            gap_top = spm_pkg::PAGE_BYTES - 1;
            free_bytes = spm_pkg::PAGE_BYTES;
            page_id = '0;
            errors = 0;
        end
        else
        begin
            if (cfg_we) page_id = cfg_wdata;
            // queue first so that a result beat on the same edge pairs with an older item
            if (in_valid && in_ready)
            begin
                predict_page_op(exp_r);
                result_fifo = {result_fifo, exp_r};
            end
            if (out_valid && out_ready)
            begin
                if (result_fifo.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with nothing outstanding", $realtime);
                end
                else
                begin
                    exp_r = result_fifo.pop_front();
                    if (status !== exp_r.status)
                        report_mismatch("status", status, exp_r.status);
                    if (result_slot !== exp_r.slot)
                        report_mismatch("result_slot", result_slot, exp_r.slot);
                    if (result_length !== exp_r.length)
                        report_mismatch("result_length", result_length, exp_r.length);
                    if (result_byte !== exp_r.data)
                        report_mismatch("result_byte", result_byte, exp_r.data);
                    if (free_space !== exp_r.free)
                        report_mismatch("free_space", free_space, exp_r.free);
                    if (record_count !== exp_r.count)
                        report_mismatch("record_count", record_count, exp_r.count);
                end
            end
        end
        pending = result_fifo.size();
        for (int i = 0; i < spm_pkg::MAX_SLOTS; i++)
        begin
            live_mask[i] = (i < slots_used) && rec_live[i];
            len_flat[i*11 +: 11] = rec_len[i][10:0];
        end
    end

endmodule

[dv/tb_slotted_page_record_manager.sv]
// tb_slotted_page_record_manager: stimulus and verdict for slotted_page_record_manager
// depends on spm_pkg, the block and spm_page_checker, which predicts and compares
`timescale 1ns / 1ps

module tb_slotted_page_record_manager;

    localparam int STALL_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  action;
    logic [15:0] request_page;
    logic [7:0]  slot_index;
    logic [10:0] record_length;
    logic [9:0]  byte_index;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [7:0]  result_slot;
    logic [10:0] result_length;
    logic [7:0]  result_byte;
    logic [10:0] free_space;
    logic [8:0]  record_count;

    int                               errors;
    int                               pending;
    logic [spm_pkg::MAX_SLOTS-1:0]    live_mask;
    logic [spm_pkg::MAX_SLOTS*11-1:0] len_flat;
    logic [15:0]                      cur_page;
    bit                               calm;
    int                               quiet_cycles = 0;
    int                               stall_left = 0;

    slotted_page_record_manager DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .action(action),
        .request_page(request_page), .slot_index(slot_index),
        .record_length(record_length), .byte_index(byte_index), .data_byte(data_byte),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .result_slot(result_slot), .result_length(result_length),
        .result_byte(result_byte), .free_space(free_space), .record_count(record_count)
    );

    spm_page_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .action(action),
        .request_page(request_page), .slot_index(slot_index),
        .record_length(record_length), .byte_index(byte_index), .data_byte(data_byte),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .result_slot(result_slot), .result_length(result_length),
        .result_byte(result_byte), .free_space(free_space), .record_count(record_count),
        .errors(errors), .pending(pending), .live_mask(live_mask), .len_flat(len_flat)
    );

    always #1 clk = ~clk;

    // result side back-pressure in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (calm || $urandom_range(0, 9) != 0)
            out_ready <= 1'b1;
        else
        begin
            stall_left <= $urandom_range(0, 18);
            out_ready <= 1'b0;
        end
    end

    // hang watchdog: cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("slotted_page_record_manager regression: fail");
            $finish;
        end
    end

    task automatic send_op(input logic [2:0] act, input logic [15:0] pg, input logic [7:0] sl,
                           input logic [10:0] len, input logic [9:0] bi, input logic [7:0] db);
        int gap;
        gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        request_page <= pg;
        slot_index <= sl;
        record_length <= len;
        byte_index <= bi;
        data_byte <= db;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain_and_set_page(input logic [15:0] pg);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= pg;
        cur_page = pg;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly well-formed requests aimed at live records, some noise
    task automatic random_op();
        int pick;
        int sl;
        int rlen;
        int len;
        int bi;
        logic [2:0] act;
        logic [15:0] pg;
        pick = $urandom_range(0, 99);
        if (pick < 25) act = spm_pkg::ACT_INSERT;
        else if (pick < 50) act = spm_pkg::ACT_WRITE;
        else if (pick < 62) act = spm_pkg::ACT_DELETE;
        else if (pick < 86) act = spm_pkg::ACT_READ;
        else if (pick < 90) act = spm_pkg::ACT_FIRST;
        else if (pick < 98) act = spm_pkg::ACT_NEXT;
        else act = 3'($urandom_range(6, 7));
        pg = ($urandom_range(0, 9) == 0) ? 16'($urandom) : cur_page;
        sl = $urandom_range(0, 255);
        if ($urandom_range(0, 9) != 0)
        begin
            for (int k = 0; k < spm_pkg::MAX_SLOTS; k++)
                if (live_mask[(sl + k) % spm_pkg::MAX_SLOTS])
                begin
                    sl = (sl + k) % spm_pkg::MAX_SLOTS;
                    break;
                end
        end
        len = len_flat[(sl % spm_pkg::MAX_SLOTS)*11 +: 11];
        if (len > 0 && $urandom_range(0, 7) != 0) bi = $urandom_range(0, len - 1);
        else bi = $urandom_range(0, 1023);
        pick = $urandom_range(0, 99);
        if (pick < 80) rlen = $urandom_range(1, 48);
        else if (pick < 95) rlen = $urandom_range(1, 400);
        else rlen = $urandom_range(0, 2047);
        send_op(act, pg, 8'(sl), 11'(rlen), 10'(bi), 8'($urandom));
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        in_valid <= 1'b0;
        action <= spm_pkg::ACT_FIRST;
        request_page <= '0;
        slot_index <= '0;
        record_length <= '0;
        byte_index <= '0;
        data_byte <= '0;
        calm = 0;
        cur_page = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty page, extremes and each error path
        send_op(spm_pkg::ACT_FIRST, 16'h0, 8'h0, 11'd0, 10'd0, 8'h00);
        send_op(spm_pkg::ACT_INSERT, 16'h0, 8'h0, 11'd0, 10'd0, 8'h00);
        send_op(spm_pkg::ACT_INSERT, 16'h0, 8'h0, 11'd1024, 10'd0, 8'h00);
        send_op(spm_pkg::ACT_INSERT, 16'h0, 8'h0, 11'd1020, 10'd0, 8'h00);
        send_op(spm_pkg::ACT_READ, 16'h0, 8'h0, 11'd0, 10'd1019, 8'h00);
        send_op(spm_pkg::ACT_WRITE, 16'h0, 8'h0, 11'd0, 10'd1019, 8'hff);
        send_op(spm_pkg::ACT_READ, 16'h0, 8'h0, 11'd0, 10'd1019, 8'h00);
        send_op(spm_pkg::ACT_READ, 16'h0, 8'h0, 11'd0, 10'd1023, 8'h00);
        send_op(spm_pkg::ACT_WRITE, 16'hffff, 8'h0, 11'd0, 10'd0, 8'h5a);
        send_op(spm_pkg::ACT_NEXT, 16'h0, 8'h0, 11'd0, 10'd0, 8'h00);
        send_op(spm_pkg::ACT_NEXT, 16'h0, 8'hff, 11'd0, 10'd0, 8'h00);
        send_op(spm_pkg::ACT_DELETE, 16'h0, 8'h5, 11'd0, 10'd0, 8'h00);
        send_op(spm_pkg::ACT_DELETE, 16'h0, 8'h0, 11'd0, 10'd0, 8'h00);
        send_op(3'd6, 16'h0, 8'h0, 11'd5, 10'd0, 8'h00);
        send_op(3'd7, 16'hffff, 8'hff, 11'd2047, 10'd1023, 8'hff);
        // fragment then force a repack
        send_op(spm_pkg::ACT_INSERT, 16'h0, 8'h0, 11'd300, 10'd0, 8'h00);
        send_op(spm_pkg::ACT_INSERT, 16'h0, 8'h0, 11'd300, 10'd0, 8'h00);
        send_op(spm_pkg::ACT_INSERT, 16'h0, 8'h0, 11'd300, 10'd0, 8'h00);
        send_op(spm_pkg::ACT_WRITE, 16'h0, 8'h2, 11'd0, 10'd7, 8'ha5);
        send_op(spm_pkg::ACT_DELETE, 16'h0, 8'h1, 11'd0, 10'd0, 8'h00);
        send_op(spm_pkg::ACT_INSERT, 16'h0, 8'h0, 11'd350, 10'd0, 8'h00);
        send_op(spm_pkg::ACT_READ, 16'h0, 8'h2, 11'd0, 10'd7, 8'h00);
        send_op(spm_pkg::ACT_DELETE, 16'h0, 8'h2, 11'd0, 10'd0, 8'h00);
        send_op(spm_pkg::ACT_NEXT, 16'h0, 8'h0, 11'd0, 10'd0, 8'h00);

        drain_and_set_page(16'hffff);
        for (int n = 0; n < 300; n++) random_op();
        drain_and_set_page(16'($urandom));
        for (int n = 0; n < 300; n++)
        begin
            if (n == 150)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            random_op();
        end
        drain_and_set_page(16'h0000);
        for (int n = 0; n < 300; n++) random_op();
        drain_and_set_page(16'h5a3c);
        for (int n = 0; n < 300; n++)
        begin
            if (n == 150) calm = 1;
            random_op();
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("slotted_page_record_manager regression: pass");
        else
            $display("slotted_page_record_manager regression: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/spm_pkg.sv
rtl/spm_ram.sv
rtl/slotted_page_record_manager.sv
rtl/spm_checker.sv
dv/spm_page_checker.sv
dv/tb_slotted_page_record_manager.sv
